@@ src/pfra_pkg.sv @@
// pfra_pkg: shared types and constants for the page frame refcount allocator
// depends on nothing; used by page_frame_refcount_allocator
package pfra_pkg;

    localparam logic [31:0] BASE_ADDR     = 32'h0010_0000;
    localparam int          PAGE_SHIFT    = 12;
    localparam logic [7:0]  RESERVED_MARK = 8'd100;
    localparam int          CFG_W         = 25;
    localparam int          BOUND_W       = 14;
    localparam logic [CFG_W-1:0] START_RESET = 25'd4194304;
    localparam logic [CFG_W-1:0] END_RESET   = 25'd16777216;

    typedef enum logic [2:0] {
        ACT_INIT  = 3'd0,
        ACT_ALLOC = 3'd1,
        ACT_FREE  = 3'd2,
        ACT_SHARE = 3'd3,
        ACT_QUERY = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OOM      = 3'd1,
        ST_BELOW    = 3'd2,
        ST_NONEXIST = 3'd3,
        ST_FREE     = 3'd4,
        ST_SAT      = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_ALLOC,
        S_ACC_RD,
        S_ACC_WR
    } state_t;

    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_END   = 2'd1;

endpackage

@@ src/pfra_ram.sv @@
// pfra_ram: generic single-write, single-read ram with registered read data
// no dependencies
module pfra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/page_frame_refcount_allocator.sv @@
// page_frame_refcount_allocator: top level, counts kept in one pfra_ram
// depends on pfra_pkg and pfra_ram
// free/share/query read the count, then write it back, before done; errors and
// unknown actions finish without a ram access; allocate scans downward (one ram
// read a cycle); init sweeps all entries, one ram write a cycle; one request at a time.
// after reset a sweep writes the reserved mark to all NUM_PAGES entries
// (busy high); the receiver cannot stall, done lasts one cycle
module page_frame_refcount_allocator
    import pfra_pkg::*;
#(
    parameter int NUM_PAGES = 3840
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [31:0] address,
    output logic        done,
    output logic [23:0] page_address,
    output logic [7:0]  ref_count,
    output logic [2:0]  status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = NUM_PAGES > 1 ? $clog2(NUM_PAGES) : 1;
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] LAST_CNT = CW'(NUM_PAGES - 1);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] start_mem_reg, end_mem_reg;
    logic [BOUND_W-1:0] first_reg, first_next, last_reg, last_next;
    logic             init_reg, init_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [IW-1:0]    scan_reg, scan_next;
    logic             live_reg, live_next;
    logic [IW-1:0]    chk_reg, chk_next;
    logic             chkv_reg, chkv_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [2:0]       act_reg, act_next;

    logic             done_reg, done_next;
    logic [23:0]      pa_reg, pa_next;
    logic [7:0]       rc_reg, rc_next;
    logic [2:0]       st_reg, st_next;

    logic             we;
    logic [IW-1:0]    waddr, raddr;
    logic [7:0]       wdata, rdata;

    logic             cfg_wr;
    logic [CFG_W-1:0] s_clamp;
    logic [CFG_W-1:0] free_bytes;
    logic [31:0]      addr_off;
    logic [19:0]      addr_idx;
    logic [31:0]      sweep_pos;

    pfra_ram #(.WIDTH(8), .DEPTH(NUM_PAGES)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    always_comb
    begin
        prdata = 32'd0;
        if ({1'b0, paddr[2]} == REG_END)
        begin
            prdata = 32'(end_mem_reg);
        end
        else
        begin
            prdata = 32'(start_mem_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_mem_reg <= START_RESET;
            end_mem_reg   <= END_RESET;
        end
        else if (cfg_wr)
        begin
            if ({1'b0, paddr[2]} == REG_END)
            begin
                end_mem_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                start_mem_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    // init bounds and address decode
    assign s_clamp    = (start_mem_reg < BASE_ADDR[CFG_W-1:0]) ? BASE_ADDR[CFG_W-1:0]
                                                               : start_mem_reg;
    assign free_bytes = end_mem_reg - s_clamp;
    assign addr_off   = address - BASE_ADDR;
    assign addr_idx   = addr_off[31:PAGE_SHIFT];
    assign sweep_pos  = 32'(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            init_reg  <= 1'b0;
            first_reg <= '0;
            last_reg  <= '0;
            cnt_reg   <= '0;
            live_reg  <= 1'b0;
            chkv_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            cnt_reg   <= cnt_next;
            live_reg  <= live_next;
            chkv_reg  <= chkv_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        chk_reg  <= chk_next;
        idx_reg  <= idx_next;
        act_reg  <= act_next;
        pa_reg   <= pa_next;
        rc_reg   <= rc_next;
        st_reg   <= st_next;
    end

    always_comb
    begin
        state_next = state_reg;
        init_next  = init_reg;
        first_next = first_reg;
        last_next  = last_reg;
        cnt_next   = cnt_reg;
        scan_next  = scan_reg;
        live_next  = live_reg;
        chk_next   = chk_reg;
        chkv_next  = chkv_reg;
        idx_next   = idx_reg;
        act_next   = act_reg;
        done_next  = 1'b0;
        pa_next    = pa_reg;
        rc_next    = rc_reg;
        st_next    = st_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = 8'd0;
        raddr      = scan_reg;

        unique case (state_reg)
            S_SWEEP:
            begin
                we    = 1'b1;
                waddr = cnt_reg[IW-1:0];
                wdata = (sweep_pos >= 32'(first_reg) && sweep_pos < 32'(last_reg))
                        ? 8'd0 : RESERVED_MARK;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = S_IDLE;
                    if (init_reg)
                    begin
                        done_next = 1'b1;
                        pa_next   = '0;
                        rc_next   = '0;
                        st_next   = ST_OK;
                    end
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    act_next = action;
                    pa_next  = '0;
                    rc_next  = '0;
                    st_next  = ST_OK;
                    unique case (action)
                        ACT_INIT:
                        begin
                            init_next = 1'b1;
                            cnt_next  = '0;
                            if (end_mem_reg <= s_clamp)
                            begin
                                first_next = '0;
                                last_next  = '0;
                            end
                            else
                            begin
                                first_next = BOUND_W'((s_clamp - BASE_ADDR[CFG_W-1:0])
                                                      >> PAGE_SHIFT);
                                last_next  = BOUND_W'((s_clamp - BASE_ADDR[CFG_W-1:0])
                                                      >> PAGE_SHIFT)
                                           + BOUND_W'(free_bytes >> PAGE_SHIFT);
                            end
                            state_next = S_SWEEP;
                        end
                        ACT_ALLOC:
                        begin
                            scan_next  = IW'(NUM_PAGES - 1);
                            live_next  = 1'b1;
                            chkv_next  = 1'b0;
                            state_next = S_ALLOC;
                        end
                        ACT_FREE, ACT_SHARE, ACT_QUERY:
                        begin
                            if (address < BASE_ADDR)
                            begin
                                st_next   = ST_BELOW;
                                done_next = 1'b1;
                            end
                            else if (address >= 32'(end_mem_reg)
                                     || 32'(addr_idx) >= 32'(NUM_PAGES))
                            begin
                                st_next   = ST_NONEXIST;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                idx_next   = addr_idx[IW-1:0];
                                state_next = S_ACC_RD;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                // one read issued per cycle, checked in the next cycle
                raddr     = scan_reg;
                chk_next  = scan_reg;
                chkv_next = live_reg;
                if (live_reg)
                begin
                    if (scan_reg == '0)
                    begin
                        live_next = 1'b0;
                    end
                    else
                    begin
                        scan_next = scan_reg - 1'b1;
                    end
                end
                if (chkv_reg)
                begin
                    if (rdata == 8'd0)
                    begin
                        we         = 1'b1;
                        waddr      = chk_reg;
                        wdata      = 8'd1;
                        pa_next    = 24'(BASE_ADDR + (32'(chk_reg) << PAGE_SHIFT));
                        rc_next    = 8'd1;
                        st_next    = ST_OK;
                        done_next  = 1'b1;
                        live_next  = 1'b0;
                        chkv_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else if (chk_reg == '0)
                    begin
                        st_next    = ST_OOM;
                        done_next  = 1'b1;
                        chkv_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            S_ACC_RD:
            begin
                raddr      = idx_reg;
                state_next = S_ACC_WR;
            end
            S_ACC_WR:
            begin
                we        = 1'b1;
                waddr     = idx_reg;
                wdata     = rdata;
                rc_next   = rdata;
                st_next   = ST_OK;
                if (act_reg == ACT_FREE)
                begin
                    if (rdata == 8'd0)
                    begin
                        st_next = ST_FREE;
                    end
                    else
                    begin
                        wdata   = rdata - 8'd1;
                        rc_next = rdata - 8'd1;
                    end
                end
                else if (act_reg == ACT_SHARE)
                begin
                    if (rdata == 8'hff)
                    begin
                        st_next = ST_SAT;
                    end
                    else
                    begin
                        wdata   = rdata + 8'd1;
                        rc_next = rdata + 8'd1;
                    end
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign page_address = pa_reg;
    assign ref_count    = rc_reg;
    assign status       = st_reg;

`ifndef ASSERT_OFF
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (st_reg <= ST_SAT))
        else $error("status code out of range");
    a_oom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && st_reg == ST_OOM) |-> (pa_reg == '0 && rc_reg == '0))
        else $error("out of memory result carries data");
    a_addr_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && pa_reg != '0) |-> (act_reg == ACT_ALLOC && rc_reg == 8'd1))
        else $error("page address on non-allocate result");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_ALLOC) |=> busy)
        else $error("allocate did not start a scan");
`endif

endmodule
